// ===== hdl/taoq_pkg.sv =====
// Package for the two-class age-ordered queue.
// Holds sizes, codes and shared types; used by taoq_fifo and the top level.
package taoq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int SEQ_BITS     = 6;
    localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_BITS   = 16;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_POP_ALL = 2'd1,
        MODE_POP_A = 2'd2,
        MODE_POP_B = 2'd3
    } t_mode;

    localparam logic [1:0] CLASS_A = 2'd0;
    localparam logic [1:0] CLASS_B = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_IGNORED = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [SEQ_BITS-1:0]     stamp;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry wentry;
    } t_fifo_ctl;

    typedef struct packed {
        logic   empty;
        logic   single;
        logic   full;
        t_entry head;
    } t_fifo_stat;

endpackage

// ===== hdl/two_class_age_ordered_queue_top.sv =====
// Top level of the two-class age-ordered queue.
// Depends on taoq_pkg and instantiates two taoq_fifo class queues.
//
// Each input beat carries one operation: add an entry to class A or B, pop the
// oldest entry of either class, or pop the head of one class. Every operation
// returns exactly one output beat with a status, the popped entry and the
// empty flags after the operation. The beat is accepted while the head entries
// are read from the class memories; then, in the execute state, the result is
// formed, the memories are written and the result register is loaded. A new
// beat is accepted only once the previous operation has executed; a result left
// waiting in the output register holds the execute state of the following
// operation. Entries carry a 6-bit arrival stamp and age ordering is exact while
// at most 32 entries are held in total.
module two_class_age_ordered_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // entry_value
    input  logic [3:0]  s_axis_tuser,  // mode, entry_class
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // popped_value, all_empty, class_a_empty,
                                       // class_b_empty, zero fill
    output logic [2:0]  m_axis_tuser   // status, popped_class
);

    taoq_pkg::t_state r_state;
    taoq_pkg::t_state n_state;

    logic in_accept;
    logic exec_go;

    taoq_pkg::t_mode                 r_mode;
    logic [1:0]                      r_class;
    logic [taoq_pkg::VALUE_BITS-1:0] r_value;
    logic [taoq_pkg::SEQ_BITS-1:0]   r_seq;

    taoq_pkg::t_fifo_ctl  a_ctl;
    taoq_pkg::t_fifo_ctl  b_ctl;
    taoq_pkg::t_fifo_stat a_stat;
    taoq_pkg::t_fifo_stat b_stat;

    taoq_pkg::t_status             status;
    logic                          pop_a;
    logic                          pop_b;
    logic                          push_a;
    logic                          push_b;
    logic [taoq_pkg::SEQ_BITS-1:0] age_diff;
    logic                          a_older;
    logic                          a_empty_after;
    logic                          b_empty_after;
    logic [taoq_pkg::VALUE_BITS-1:0] pop_value;

    logic                            r_out_valid;
    taoq_pkg::t_status               r_out_status;
    logic                            r_out_class;
    logic [taoq_pkg::VALUE_BITS-1:0] r_out_value;
    logic                            r_out_a_empty;
    logic                            r_out_b_empty;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            taoq_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = taoq_pkg::ST_EXEC;
                end
            end
            taoq_pkg::ST_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = taoq_pkg::ST_IDLE;
                end
            end
            default: n_state = taoq_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        exec_go       = 1'b0;
        unique case (r_state)
            taoq_pkg::ST_IDLE: s_axis_tready = 1'b1;
            taoq_pkg::ST_EXEC: exec_go = !r_out_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= taoq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= taoq_pkg::t_mode'(s_axis_tuser[1:0]);
            r_class <= s_axis_tuser[3:2];
            r_value <= s_axis_tdata;
        end
    end

    assign age_diff = a_stat.head.stamp - b_stat.head.stamp;
    assign a_older  = age_diff[taoq_pkg::SEQ_BITS-1];

    // Operation decode against the head entries read in the accept cycle.
    always_comb begin
        status = taoq_pkg::STAT_OK;
        pop_a  = 1'b0;
        pop_b  = 1'b0;
        push_a = 1'b0;
        push_b = 1'b0;
        unique case (r_mode)
            taoq_pkg::MODE_ADD: begin
                priority if (r_class == taoq_pkg::CLASS_A) begin
                    if (a_stat.full) begin
                        status = taoq_pkg::STAT_FULL;
                    end else begin
                        push_a = 1'b1;
                    end
                end else if (r_class == taoq_pkg::CLASS_B) begin
                    if (b_stat.full) begin
                        status = taoq_pkg::STAT_FULL;
                    end else begin
                        push_b = 1'b1;
                    end
                end else begin
                    status = taoq_pkg::STAT_IGNORED;
                end
            end
            taoq_pkg::MODE_POP_ALL: begin
                priority if (!a_stat.empty && !b_stat.empty) begin
                    pop_a = a_older;
                    pop_b = !a_older;
                end else if (!a_stat.empty) begin
                    pop_a = 1'b1;
                end else if (!b_stat.empty) begin
                    pop_b = 1'b1;
                end else begin
                    status = taoq_pkg::STAT_EMPTY;
                end
            end
            taoq_pkg::MODE_POP_A: begin
                if (a_stat.empty) begin
                    status = taoq_pkg::STAT_EMPTY;
                end else begin
                    pop_a = 1'b1;
                end
            end
            taoq_pkg::MODE_POP_B: begin
                if (b_stat.empty) begin
                    status = taoq_pkg::STAT_EMPTY;
                end else begin
                    pop_b = 1'b1;
                end
            end
            default: status = taoq_pkg::STAT_OK;
        endcase
    end

    always_comb begin
        pop_value = '0;
        if (pop_a) begin
            pop_value = taoq_pkg::VALUE_BITS'(a_stat.head.payload);
        end else if (pop_b) begin
            pop_value = taoq_pkg::VALUE_BITS'(b_stat.head.payload);
        end
    end

    assign a_empty_after = pop_a ? a_stat.single : (a_stat.empty && !push_a);
    assign b_empty_after = pop_b ? b_stat.single : (b_stat.empty && !push_b);

    assign a_ctl.push          = exec_go && push_a;
    assign a_ctl.pop           = exec_go && pop_a;
    assign a_ctl.wentry.stamp  = r_seq;
    assign a_ctl.wentry.payload = taoq_pkg::PAYLOAD_BITS'(r_value);
    assign b_ctl.push          = exec_go && push_b;
    assign b_ctl.pop           = exec_go && pop_b;
    assign b_ctl.wentry.stamp  = r_seq;
    assign b_ctl.wentry.payload = taoq_pkg::PAYLOAD_BITS'(r_value);

    taoq_fifo u_fifo_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (a_ctl),
        .o_stat  (a_stat)
    );

    taoq_fifo u_fifo_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (b_ctl),
        .o_stat  (b_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_go && (push_a || push_b)) begin
                r_seq <= r_seq + 1'b1;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_status  <= status;
            r_out_class   <= pop_b;
            r_out_value   <= pop_value;
            r_out_a_empty <= a_empty_after;
            r_out_b_empty <= b_empty_after;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_class, r_out_status};
    assign m_axis_tdata  = {5'd0, r_out_b_empty, r_out_a_empty,
                            r_out_a_empty && r_out_b_empty, r_out_value};

endmodule

// ===== hdl/taoq_fifo.sv =====
// One class FIFO: a synchronous entry memory plus head and fill registers.
// Depends on taoq_pkg for sizes and the control and status structs.
module taoq_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  taoq_pkg::t_fifo_ctl  i_ctl,
    output taoq_pkg::t_fifo_stat o_stat
);

    taoq_pkg::t_entry r_mem [taoq_pkg::QUEUE_DEPTH];
    taoq_pkg::t_entry r_rd;

    logic [taoq_pkg::PTR_BITS-1:0]  r_head;
    logic [taoq_pkg::PTR_BITS-1:0]  n_head;
    logic [taoq_pkg::FILL_BITS-1:0] r_fill;
    logic [taoq_pkg::FILL_BITS-1:0] n_fill;
    logic [taoq_pkg::FILL_BITS:0]   tail_sum;
    logic [taoq_pkg::PTR_BITS-1:0]  tail;

    always_comb begin
        tail_sum = (taoq_pkg::FILL_BITS + 1)'(r_head) + (taoq_pkg::FILL_BITS + 1)'(r_fill);
        if (tail_sum >= (taoq_pkg::FILL_BITS + 1)'(taoq_pkg::QUEUE_DEPTH)) begin
            tail = taoq_pkg::PTR_BITS'(tail_sum - (taoq_pkg::FILL_BITS + 1)'(taoq_pkg::QUEUE_DEPTH));
        end else begin
            tail = taoq_pkg::PTR_BITS'(tail_sum);
        end
    end

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctl.pop) begin
            if (r_head == taoq_pkg::PTR_BITS'(taoq_pkg::QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
            n_fill = r_fill - 1'b1;
        end else if (i_ctl.push) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail] <= i_ctl.wentry;
        end
        r_rd <= r_mem[r_head];
    end

    assign o_stat.empty  = (r_fill == '0);
    assign o_stat.single = (r_fill == taoq_pkg::FILL_BITS'(1));
    assign o_stat.full   = (r_fill == taoq_pkg::FILL_BITS'(taoq_pkg::QUEUE_DEPTH));
    assign o_stat.head   = r_rd;

endmodule
